// ===== rtl/mpi_pkg.sv =====
// Shared constants, types and helper functions for the Mandelbrot pixel intensity block.
package mpi_pkg;

    localparam int PIX_W     = 12;
    localparam int FRAC_BITS = 24;
    localparam int DIV_W     = PIX_W + FRAC_BITS;
    localparam int Q_W       = 32;
    localparam int PROD_W    = 2 * Q_W;
    localparam int SQ_W      = PROD_W - FRAC_BITS;
    localparam int WIDE_W    = SQ_W + 2;
    localparam int N_ITER    = 21;
    localparam int MAX_STEPS = 20;
    localparam int STEP_W    = 5;
    localparam int GREY_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [PIX_W-1:0] DIVISOR_RESET = 12'd600;

    localparam logic signed [Q_W-1:0] Q_ONE_HALF     = 32'sh0080_0000;
    localparam logic signed [Q_W-1:0] Q_THREE_HALVES = 32'sh0180_0000;
    localparam logic [SQ_W:0]         ESC_LIMIT      = 41'h000_0400_0000;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    // Grey level 255*steps/20, truncated, for the step counts that escaped.
    localparam logic [GREY_W-1:0] GREY_LUT [0:MAX_STEPS-1] = '{
        8'd0,   8'd12,  8'd25,  8'd38,  8'd51,  8'd63,  8'd76,  8'd89,  8'd102, 8'd114,
        8'd127, 8'd140, 8'd153, 8'd165, 8'd178, 8'd191, 8'd204, 8'd216, 8'd229, 8'd242
    };

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] rem_x;
        logic [DIV_W-1:0] acc_x;
        logic [PIX_W-1:0] rem_y;
        logic [DIV_W-1:0] acc_y;
    } t_div_tok;

    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic [STEP_W-1:0]       steps;
        logic signed [Q_W-1:0]   c_re;
        logic signed [Q_W-1:0]   c_im;
        logic signed [Q_W-1:0]   re;
        logic signed [Q_W-1:0]   im;
    } t_orbit;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > WIDE_W'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < WIDE_W'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [GREY_W-1:0] grey_level(input logic [STEP_W-1:0] steps);
        logic [GREY_W-1:0] g;
        if (steps < STEP_W'(MAX_STEPS)) begin
            g = GREY_LUT[steps];
        end else begin
            g = '0;
        end
        return g;
    endfunction

endpackage

// ===== rtl/mpi_ifs.sv =====
// Handshake interfaces for the pixel, result and configuration channels.
interface mpi_pix_if;
    logic                       valid;
    logic                       ready;
    logic [mpi_pkg::PIX_W-1:0]  pixel_x;
    logic [mpi_pkg::PIX_W-1:0]  pixel_y;

    modport source(output valid, output pixel_x, output pixel_y, input ready);
    modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mpi_res_if;
    logic                       valid;
    logic                       ready;
    logic [mpi_pkg::GREY_W-1:0] intensity;

    modport source(output valid, output intensity, input ready);
    modport sink(input valid, input intensity, output ready);
endinterface

interface mpi_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mpi_pkg::CFG_IDX_W-1:0] index;
    logic [mpi_pkg::PIX_W-1:0]     data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/mpi_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit for both coordinates.
module mpi_div_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [mpi_pkg::PIX_W-1:0] i_div_x,
    input  logic [mpi_pkg::PIX_W-1:0] i_div_y,
    input  mpi_pkg::t_div_tok         i_tok,
    output mpi_pkg::t_div_tok         o_tok
);

    typedef struct packed {
        logic [mpi_pkg::PIX_W-1:0] rem;
        logic [mpi_pkg::DIV_W-1:0] acc;
    } t_lane;

    function automatic t_lane div_step(input logic [mpi_pkg::PIX_W-1:0] rem,
                                       input logic [mpi_pkg::DIV_W-1:0] acc,
                                       input logic [mpi_pkg::PIX_W-1:0] d);
        logic [mpi_pkg::PIX_W:0] t;
        logic [mpi_pkg::PIX_W:0] diff;
        logic                    ge;
        t_lane                   r;
        t    = {rem, acc[mpi_pkg::DIV_W-1]};
        diff = t - {1'b0, d};
        ge   = (t >= {1'b0, d});
        r.rem = ge ? diff[mpi_pkg::PIX_W-1:0] : t[mpi_pkg::PIX_W-1:0];
        r.acc = {acc[mpi_pkg::DIV_W-2:0], ge};
        return r;
    endfunction

    t_lane             lane_x;
    t_lane             lane_y;
    mpi_pkg::t_div_tok r_tok;

    assign lane_x = div_step(i_tok.rem_x, i_tok.acc_x, i_div_x);
    assign lane_y = div_step(i_tok.rem_y, i_tok.acc_y, i_div_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok.valid <= i_tok.valid;
        end
        if (i_en) begin
            r_tok.rem_x <= lane_x.rem;
            r_tok.acc_x <= lane_x.acc;
            r_tok.rem_y <= lane_y.rem;
            r_tok.acc_y <= lane_y.acc;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/mpi_iter_cell.sv =====
// One orbit cell: squares the point in one stage, then tests escape and updates z.
module mpi_iter_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  mpi_pkg::t_orbit i_orbit,
    output mpi_pkg::t_orbit o_orbit
);

    typedef struct packed {
        logic                              valid;
        logic                              done;
        logic [mpi_pkg::STEP_W-1:0]        steps;
        logic signed [mpi_pkg::Q_W-1:0]    c_re;
        logic signed [mpi_pkg::Q_W-1:0]    c_im;
    } t_sq_stage;

    logic signed [mpi_pkg::Q_W-1:0]     re_s;
    logic signed [mpi_pkg::Q_W-1:0]     im_s;
    t_sq_stage                          r_a;
    logic signed [mpi_pkg::PROD_W-1:0]  r_re2p;
    logic signed [mpi_pkg::PROD_W-1:0]  r_im2p;
    logic signed [mpi_pkg::PROD_W-1:0]  r_reimp;

    logic signed [mpi_pkg::SQ_W-1:0]    re2;
    logic signed [mpi_pkg::SQ_W-1:0]    im2;
    logic signed [mpi_pkg::SQ_W-1:0]    reim;
    logic [mpi_pkg::SQ_W:0]             mag;
    logic                               escape;
    logic signed [mpi_pkg::WIDE_W-1:0]  re_wide;
    logic signed [mpi_pkg::WIDE_W-1:0]  im_wide;
    mpi_pkg::t_orbit                    n_orbit;
    mpi_pkg::t_orbit                    r_orbit;

    assign re_s = i_orbit.re;
    assign im_s = i_orbit.im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (i_en) begin
            r_a.valid <= i_orbit.valid;
        end
        if (i_en) begin
            r_a.done  <= i_orbit.done;
            r_a.steps <= i_orbit.steps;
            r_a.c_re  <= i_orbit.c_re;
            r_a.c_im  <= i_orbit.c_im;
            r_re2p    <= re_s * re_s;
            r_im2p    <= im_s * im_s;
            r_reimp   <= re_s * im_s;
        end
    end

    // Taking the upper bits of a product is a floor shift by the fraction width.
    assign re2  = r_re2p[mpi_pkg::PROD_W-1:mpi_pkg::FRAC_BITS];
    assign im2  = r_im2p[mpi_pkg::PROD_W-1:mpi_pkg::FRAC_BITS];
    assign reim = r_reimp[mpi_pkg::PROD_W-1:mpi_pkg::FRAC_BITS];

    // Both squares are non-negative, so an unsigned sum one bit wider is exact.
    assign mag    = {1'b0, re2} + {1'b0, im2};
    assign escape = (mag >= mpi_pkg::ESC_LIMIT);

    assign re_wide = mpi_pkg::WIDE_W'(re2) - mpi_pkg::WIDE_W'(im2)
                   + mpi_pkg::WIDE_W'(r_a.c_re);
    assign im_wide = (mpi_pkg::WIDE_W'(reim) <<< 1) + mpi_pkg::WIDE_W'(r_a.c_im);

    always_comb begin
        n_orbit.valid = r_a.valid;
        n_orbit.c_re  = r_a.c_re;
        n_orbit.c_im  = r_a.c_im;
        n_orbit.done  = r_a.done | escape;
        n_orbit.steps = r_a.steps;
        n_orbit.re    = mpi_pkg::sat_q(re_wide);
        n_orbit.im    = mpi_pkg::sat_q(im_wide);
        if (!(r_a.done || escape)) begin
            n_orbit.steps = r_a.steps + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orbit.valid <= 1'b0;
        end else if (i_en) begin
            r_orbit.valid <= n_orbit.valid;
        end
        if (i_en) begin
            r_orbit.done  <= n_orbit.done;
            r_orbit.steps <= n_orbit.steps;
            r_orbit.c_re  <= n_orbit.c_re;
            r_orbit.c_im  <= n_orbit.c_im;
            r_orbit.re    <= n_orbit.re;
            r_orbit.im    <= n_orbit.im;
        end
    end

    assign o_orbit = r_orbit;

endmodule

// ===== rtl/mandelbrot_pixel_intensity.sv =====
// Path: a pixel transfer passes 36 division cells, then 21 orbit cells of two stages each,
// then the output register, before its result appears.
// Throughput: one pixel per cycle; the whole cell chain advances in lockstep and
// freezes while a finished result waits to be taken at the output register.
// Reset clears every pipeline valid flag and sets both image divisors to 600.
module mandelbrot_pixel_intensity (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpi_pix_if.sink    i_pix,
    mpi_res_if.source  o_res,
    mpi_cfg_if.sink    i_cfg
);

    logic [mpi_pkg::PIX_W-1:0]   r_width;
    logic [mpi_pkg::PIX_W-1:0]   r_height;
    logic [mpi_pkg::PIX_W-1:0]   div_x;
    logic [mpi_pkg::PIX_W-1:0]   div_y;
    logic                        en;
    logic                        r_out_valid;
    logic [mpi_pkg::GREY_W-1:0]  r_intensity;

    mpi_pkg::t_div_tok           div_tok [0:mpi_pkg::DIV_W];
    mpi_pkg::t_orbit             orbit   [0:mpi_pkg::N_ITER];

    logic [mpi_pkg::DIV_W-1:0]   q_x;
    logic [mpi_pkg::DIV_W-1:0]   q_y;
    logic signed [mpi_pkg::Q_W-1:0] qs_x;
    logic signed [mpi_pkg::Q_W-1:0] qs_y;

    // Configuration.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mpi_pkg::DIVISOR_RESET;
            r_height <= mpi_pkg::DIVISOR_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mpi_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg.data;
                mpi_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A zero divisor behaves as one.
    assign div_x = (r_width  == '0) ? mpi_pkg::PIX_W'(1) : r_width;
    assign div_y = (r_height == '0) ? mpi_pkg::PIX_W'(1) : r_height;

    assign en          = !r_out_valid || o_res.ready;
    assign i_pix.ready = en;

    assign div_tok[0].valid = i_pix.valid;
    assign div_tok[0].rem_x = '0;
    assign div_tok[0].acc_x = {i_pix.pixel_x, mpi_pkg::FRAC_BITS'(0)};
    assign div_tok[0].rem_y = '0;
    assign div_tok[0].acc_y = {i_pix.pixel_y, mpi_pkg::FRAC_BITS'(0)};

    for (genvar gi = 0; gi < mpi_pkg::DIV_W; gi++) begin : g_div
        mpi_div_cell u_div_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_div_x (div_x),
            .i_div_y (div_y),
            .i_tok   (div_tok[gi]),
            .o_tok   (div_tok[gi+1])
        );
    end

    // Quotients above the Q8.24 range clamp to its maximum before the offset.
    assign q_x  = div_tok[mpi_pkg::DIV_W].acc_x;
    assign q_y  = div_tok[mpi_pkg::DIV_W].acc_y;
    assign qs_x = (q_x[mpi_pkg::DIV_W-1:mpi_pkg::Q_W-1] != '0) ? mpi_pkg::Q_MAX
                : q_x[mpi_pkg::Q_W-1:0];
    assign qs_y = (q_y[mpi_pkg::DIV_W-1:mpi_pkg::Q_W-1] != '0) ? mpi_pkg::Q_MAX
                : q_y[mpi_pkg::Q_W-1:0];

    assign orbit[0].valid = div_tok[mpi_pkg::DIV_W].valid;
    assign orbit[0].done  = 1'b0;
    assign orbit[0].steps = '0;
    assign orbit[0].c_re  = qs_x - mpi_pkg::Q_THREE_HALVES;
    assign orbit[0].c_im  = qs_y - mpi_pkg::Q_ONE_HALF;
    assign orbit[0].re    = '0;
    assign orbit[0].im    = '0;

    for (genvar gk = 0; gk < mpi_pkg::N_ITER; gk++) begin : g_iter
        mpi_iter_cell u_iter_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_orbit (orbit[gk]),
            .o_orbit (orbit[gk+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= orbit[mpi_pkg::N_ITER].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_intensity <= mpi_pkg::grey_level(orbit[mpi_pkg::N_ITER].steps);
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.intensity = r_intensity;

    // A point that never escaped must have run every iteration.
    a_full_orbit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        orbit[mpi_pkg::N_ITER].valid && !orbit[mpi_pkg::N_ITER].done
        |-> orbit[mpi_pkg::N_ITER].steps == mpi_pkg::STEP_W'(mpi_pkg::N_ITER))
        else $error("unescaped point left the chain with a short step count");

    // The division remainder stays below the divisor after the last cell.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_tok[mpi_pkg::DIV_W].valid
        |-> (div_tok[mpi_pkg::DIV_W].rem_x < div_x) && (div_tok[mpi_pkg::DIV_W].rem_y < div_y))
        else $error("division remainder not below divisor");

    // The chain only stops when a finished result is waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> o_res.valid && !o_res.ready)
        else $error("input stalled without a pending result");

    // A result taken while a new one arrives is replaced on the next edge.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && orbit[mpi_pkg::N_ITER].valid |=> o_res.valid)
        else $error("finished orbit did not reach the output register");

endmodule
